// ----- design/dfiir_pkg.sv -----
// Shared types, constants and helper functions of the direct-form IIR filter.
package dfiir_pkg;

   localparam int DEF_MAX_POLES            = 20;
   localparam int DEF_WEIGHT_FRACTION_BITS = 24;

   localparam int SAMPLE_W    = 24;
   localparam int WEIGHT_W    = 48;
   localparam int GAIN_W      = 48;
   localparam int HIST_W      = 64;
   localparam int POLES_W     = 5;
   localparam int OP_W        = 2;
   localparam int CSR_DATA_W  = 48;
   localparam int HROW_W      = SAMPLE_W + HIST_W;
   localparam int GAIN_FRAC_W = 32;

   // Operand digits of the shared multiplier: weights and gain split 24/24,
   // stored sums split 32/32. Low digits are unsigned, high digits signed.
   localparam int WDIG_W  = 24;
   localparam int HDIG_W  = 32;
   localparam int MUL_A_W = WDIG_W + 1;
   localparam int MUL_B_W = HDIG_W + 1;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   localparam int STEP_W     = 3;
   localparam int TAP_STEPS  = 6;
   localparam int GAIN_STEPS = 4;

   localparam logic [POLES_W-1:0]       POLES_RESET = 5'd2;
   localparam logic signed [GAIN_W-1:0] GAIN_RESET  = 48'sh0001_0000_0000;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7F_FFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh80_0000;

   typedef enum logic [OP_W-1:0] {
      OP_SAMPLE   = 2'd0,
      OP_FF_WRITE = 2'd1,
      OP_FB_WRITE = 2'd2,
      OP_CLEAR    = 2'd3
   } op_type;

   typedef enum logic {
      CSR_ACTIVE_POLES = 1'b0,
      CSR_OUTPUT_GAIN  = 1'b1
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TAP,
      ST_TAP_END,
      ST_SAT,
      ST_GAIN,
      ST_GAIN_END,
      ST_DONE
   } state_type;

   // Which digit pair the multiplier takes and where the product lands.
   typedef enum logic [3:0] {
      PRD_FF_LO,
      PRD_FF_HI,
      PRD_FB_LL,
      PRD_FB_LH,
      PRD_FB_HL,
      PRD_FB_HH,
      PRD_G_LL,
      PRD_G_LH,
      PRD_G_HL,
      PRD_G_HH
   } prd_type;

   typedef enum logic {
      INIT_SAMPLE,
      INIT_ROUND
   } init_type;

   typedef struct packed {
      logic     issue;
      prd_type  step;
      logic     acc_load;
      init_type init_sel;
      logic     y_load;
      logic     rd_en;
      logic     shift_we;
      logic     final_we;
      logic     out_load;
      logic     hist_clear;
   } seq_ctl_type;

   function automatic prd_type tap_step(input logic [STEP_W-1:0] k);
      prd_type s;
      unique case (k)
         3'd0:    s = PRD_FF_LO;
         3'd1:    s = PRD_FF_HI;
         3'd2:    s = PRD_FB_LL;
         3'd3:    s = PRD_FB_LH;
         3'd4:    s = PRD_FB_HL;
         default: s = PRD_FB_HH;
      endcase
      return s;
   endfunction

   function automatic prd_type gain_step(input logic [STEP_W-1:0] k);
      prd_type s;
      unique case (k)
         3'd0:    s = PRD_G_LL;
         3'd1:    s = PRD_G_LH;
         3'd2:    s = PRD_G_HL;
         default: s = PRD_G_HH;
      endcase
      return s;
   endfunction

endpackage

// ----- design/dfiir_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module dfiir_ram import dfiir_pkg::*; #(
   parameter int WIDTH = WEIGHT_W,
   parameter int DEPTH = DEF_MAX_POLES,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/dfiir_mac.sv -----
// Shared multiply-accumulate unit: one digit product per cycle into a wide accumulator.
module dfiir_mac import dfiir_pkg::*; #(
   parameter int MAX_POLES            = DEF_MAX_POLES,
   parameter int WEIGHT_FRACTION_BITS = DEF_WEIGHT_FRACTION_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  seq_ctl_type                ctl,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  logic signed [WEIGHT_W-1:0] ff_weight,
   input  logic signed [WEIGHT_W-1:0] fb_weight,
   input  logic signed [SAMPLE_W-1:0] hist_in,
   input  logic signed [HIST_W-1:0]   hist_out,
   input  logic signed [GAIN_W-1:0]   gain,
   output logic signed [HIST_W-1:0]   sum_sat,
   output logic signed [SAMPLE_W-1:0] out_sample,
   output logic                       out_clip
);

   localparam int F          = WEIGHT_FRACTION_BITS;
   localparam int FB_TERM_W  = WEIGHT_W + HIST_W;
   localparam int FF_TERM_W  = WEIGHT_W + SAMPLE_W + F;
   localparam int X_TERM_W   = SAMPLE_W + 2 * F;
   localparam int T1_W       = (FB_TERM_W > FF_TERM_W) ? FB_TERM_W : FF_TERM_W;
   localparam int TERM_W     = (T1_W > X_TERM_W) ? T1_W : X_TERM_W;
   localparam int ACC_W      = TERM_W + $clog2(2 * MAX_POLES + 2);
   localparam int Y_LSB      = F;
   localparam int Y_MSB      = F + HIST_W - 1;
   localparam int O_LSB      = F + GAIN_FRAC_W;
   localparam int O_MSB      = O_LSB + SAMPLE_W - 1;

   logic signed [MUL_A_W-1:0] a_dig;
   logic signed [MUL_B_W-1:0] b_dig;
   logic signed [PROD_W-1:0]  prod_in, prod_ff;
   prd_type                   step_ff;
   logic                      vld_ff;
   logic signed [ACC_W-1:0]   ext, term, acc_in, acc_ff;
   logic signed [HIST_W-1:0]  y_ff;
   logic [ACC_W-1:Y_MSB]      y_top;
   logic [ACC_W-1:O_MSB]      o_top;
   logic                      y_fits;

   // Digit selection for the multiplier.
   always_comb begin
      a_dig = '0;
      b_dig = '0;
      unique case (ctl.step)
         PRD_FF_LO: begin
            a_dig = {1'b0, ff_weight[WDIG_W-1:0]};
            b_dig = MUL_B_W'(hist_in);
         end
         PRD_FF_HI: begin
            a_dig = {ff_weight[WEIGHT_W-1], ff_weight[WEIGHT_W-1:WDIG_W]};
            b_dig = MUL_B_W'(hist_in);
         end
         PRD_FB_LL: begin
            a_dig = {1'b0, fb_weight[WDIG_W-1:0]};
            b_dig = {1'b0, hist_out[HDIG_W-1:0]};
         end
         PRD_FB_LH: begin
            a_dig = {1'b0, fb_weight[WDIG_W-1:0]};
            b_dig = {hist_out[HIST_W-1], hist_out[HIST_W-1:HDIG_W]};
         end
         PRD_FB_HL: begin
            a_dig = {fb_weight[WEIGHT_W-1], fb_weight[WEIGHT_W-1:WDIG_W]};
            b_dig = {1'b0, hist_out[HDIG_W-1:0]};
         end
         PRD_FB_HH: begin
            a_dig = {fb_weight[WEIGHT_W-1], fb_weight[WEIGHT_W-1:WDIG_W]};
            b_dig = {hist_out[HIST_W-1], hist_out[HIST_W-1:HDIG_W]};
         end
         PRD_G_LL: begin
            a_dig = {1'b0, gain[WDIG_W-1:0]};
            b_dig = {1'b0, y_ff[HDIG_W-1:0]};
         end
         PRD_G_LH: begin
            a_dig = {1'b0, gain[WDIG_W-1:0]};
            b_dig = {y_ff[HIST_W-1], y_ff[HIST_W-1:HDIG_W]};
         end
         PRD_G_HL: begin
            a_dig = {gain[GAIN_W-1], gain[GAIN_W-1:WDIG_W]};
            b_dig = {1'b0, y_ff[HDIG_W-1:0]};
         end
         PRD_G_HH: begin
            a_dig = {gain[GAIN_W-1], gain[GAIN_W-1:WDIG_W]};
            b_dig = {y_ff[HIST_W-1], y_ff[HIST_W-1:HDIG_W]};
         end
         default: begin
            a_dig = '0;
            b_dig = '0;
         end
      endcase
      prod_in = a_dig * b_dig;
   end

   // Align the registered product to its weight in the sum.
   always_comb begin
      ext = ACC_W'(prod_ff);
      unique case (step_ff)
         PRD_FF_LO:             term = ext <<< F;
         PRD_FF_HI:             term = ext <<< (F + WDIG_W);
         PRD_FB_LH, PRD_G_LH:   term = ext <<< HDIG_W;
         PRD_FB_HL, PRD_G_HL:   term = ext <<< WDIG_W;
         PRD_FB_HH, PRD_G_HH:   term = ext <<< (WDIG_W + HDIG_W);
         default:               term = ext;
      endcase
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctl.acc_load) begin
         unique case (ctl.init_sel)
            INIT_SAMPLE: acc_in = ACC_W'(sample) <<< (2 * F);
            INIT_ROUND:  acc_in = ACC_W'(1) <<< (F + GAIN_FRAC_W - 1);
            default:     acc_in = '0;
         endcase
      end else if (vld_ff) begin
         acc_in = acc_ff + term;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= ctl.issue;
      end
      prod_ff <= prod_in;
      step_ff <= ctl.step;
      acc_ff  <= acc_in;
      if (ctl.y_load) begin
         y_ff <= sum_sat;
      end
   end

   // The stored sum is the accumulator floored by F bits, clamped to 64 bits.
   always_comb begin
      y_top  = acc_ff[ACC_W-1:Y_MSB];
      y_fits = (&y_top) | ~(|y_top);
      if (y_fits) begin
         sum_sat = acc_ff[Y_MSB:Y_LSB];
      end else if (acc_ff[ACC_W-1]) begin
         sum_sat = {1'b1, {(HIST_W-1){1'b0}}};
      end else begin
         sum_sat = {1'b0, {(HIST_W-1){1'b1}}};
      end
   end

   always_comb begin
      o_top    = acc_ff[ACC_W-1:O_MSB];
      out_clip = !((&o_top) | ~(|o_top));
      if (!out_clip) begin
         out_sample = acc_ff[O_MSB:O_LSB];
      end else if (acc_ff[ACC_W-1]) begin
         out_sample = SAMPLE_MIN;
      end else begin
         out_sample = SAMPLE_MAX;
      end
   end

endmodule

// ----- design/dfiir_ctrl.sv -----
// Sequencer that walks the taps and steps the shared multiply-accumulate unit.
module dfiir_ctrl import dfiir_pkg::*; #(
   parameter int MAX_POLES = DEF_MAX_POLES,
   localparam int AW       = (MAX_POLES > 1) ? $clog2(MAX_POLES) : 1,
   localparam int NW       = $clog2(MAX_POLES + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [OP_W-1:0]     req_operation,
   output logic                req_ready,
   input  logic [NW-1:0]       pole_count,
   input  logic                rsp_free,
   output seq_ctl_type         ctl,
   output logic [AW-1:0]       rd_addr,
   output logic [AW-1:0]       wr_addr
);

   state_type           state_ff, state_in;
   logic [AW-1:0]       j_ff, j_in;
   logic [STEP_W-1:0]   k_ff, k_in;
   logic                last_tap;

   assign last_tap = (j_ff == AW'(pole_count - NW'(1)));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      ctl       = '0;
      req_ready = 1'b0;
      rd_addr   = j_ff;
      wr_addr   = AW'(pole_count - NW'(1));
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (op_type'(req_operation))
                  OP_SAMPLE: begin
                     ctl.acc_load = 1'b1;
                     ctl.init_sel = INIT_SAMPLE;
                     j_in         = '0;
                     k_in         = '0;
                     if (pole_count == '0) begin
                        state_in = ST_SAT;
                     end else begin
                        ctl.rd_en = 1'b1;
                        rd_addr   = '0;
                        state_in  = ST_TAP;
                     end
                  end
                  OP_CLEAR: begin
                     ctl.hist_clear = 1'b1;
                  end
                  OP_FF_WRITE, OP_FB_WRITE: begin
                     state_in = ST_IDLE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_TAP: begin
            ctl.issue = 1'b1;
            ctl.step  = tap_step(k_ff);
            // Each tap moves one place toward the oldest end as it is read.
            if (k_ff == '0 && j_ff != '0) begin
               ctl.shift_we = 1'b1;
               wr_addr      = j_ff - AW'(1);
            end
            if (k_ff == STEP_W'(TAP_STEPS - 1)) begin
               k_in = '0;
               if (last_tap) begin
                  state_in = ST_TAP_END;
               end else begin
                  ctl.rd_en = 1'b1;
                  rd_addr   = j_ff + AW'(1);
                  j_in      = j_ff + AW'(1);
               end
            end else begin
               k_in = k_ff + STEP_W'(1);
            end
         end
         ST_TAP_END: begin
            state_in = ST_SAT;
         end
         ST_SAT: begin
            ctl.y_load   = 1'b1;
            ctl.final_we = (pole_count != '0);
            ctl.acc_load = 1'b1;
            ctl.init_sel = INIT_ROUND;
            k_in         = '0;
            state_in     = ST_GAIN;
         end
         ST_GAIN: begin
            ctl.issue = 1'b1;
            ctl.step  = gain_step(k_ff);
            if (k_ff == STEP_W'(GAIN_STEPS - 1)) begin
               k_in     = '0;
               state_in = ST_GAIN_END;
            end else begin
               k_in = k_ff + STEP_W'(1);
            end
         end
         ST_GAIN_END: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               ctl.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- design/direct_form_iir_filter_top.sv -----
// Top level of the direct-form-I recursive filter with its weight and history stores.
//
// The request channel takes one word per handshake. Operation sample runs the
// filter on sample_in and returns exactly one result word on the response
// channel; the feedforward and feedback weight writes and the history clear
// return nothing and leave the sequencer in its idle state.
// A sample word keeps req_ready low from its acceptance until the sequencer has
// swept the taps in use, drained the multiplier register, clamped the sum,
// applied the output gain and handed the result on. The result word is shown
// in the same cycle as req_ready returns high when the output register is free.
// The work runs on the single 25 x 33 bit multiplier: each tap needs six digit
// products and the output gain four more, one product per cycle.
// The result sits in an output register, so a new request word is taken while
// an earlier result still waits. If the receiver stalls and a second result is
// ready, the sequencer holds it until the output register frees up.
// Reset (synchronous, active high) empties the output register, zeroes both
// histories through their valid bits, and sets active_poles to 2 and
// output_gain to 1.0. Weights hold garbage until written. Configuration
// writes are always accepted and should only be issued while the block idles.
module direct_form_iir_filter_top import dfiir_pkg::*; #(
   parameter int MAX_POLES            = DEF_MAX_POLES,
   parameter int WEIGHT_FRACTION_BITS = DEF_WEIGHT_FRACTION_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [OP_W-1:0]              req_operation,
   input  logic signed [SAMPLE_W-1:0]   req_sample_in,
   input  logic [POLES_W-1:0]           req_weight_index,
   input  logic signed [WEIGHT_W-1:0]   req_weight_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [SAMPLE_W-1:0]   rsp_sample_out,
   output logic                         rsp_clipped,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic                         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   localparam int AW = (MAX_POLES > 1) ? $clog2(MAX_POLES) : 1;
   localparam int NW = $clog2(MAX_POLES + 1);

   // Configuration registers.
   logic [POLES_W-1:0]         active_poles_ff, active_poles_in;
   logic signed [GAIN_W-1:0]   gain_ff, gain_in;
   logic [NW-1:0]              pole_count;

   // Handshake and sequencing.
   logic                       req_fire;
   logic                       weight_ok;
   logic                       rsp_free;
   seq_ctl_type                ctl;
   logic [AW-1:0]              rd_addr, wr_addr;

   // Stores and history bookkeeping.
   logic [WEIGHT_W-1:0]        ff_rd, fb_rd;
   logic [HROW_W-1:0]          hist_rd, hist_wdata;
   logic [MAX_POLES-1:0]       hist_vld_ff, hist_vld_in;
   logic                       rd_vld_ff;
   logic signed [SAMPLE_W-1:0] hist_in_m, x_ff;
   logic signed [HIST_W-1:0]   hist_out_m, sum_sat;

   // Output register.
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, out_sample;
   logic                       rsp_clipped_ff, out_clip;

   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign weight_ok = (int'(req_weight_index) < MAX_POLES);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // Pole counts above the store depth use the whole store.
   always_comb begin
      if (int'(active_poles_ff) > MAX_POLES) begin
         pole_count = NW'(MAX_POLES);
      end else begin
         pole_count = NW'(active_poles_ff);
      end
   end

   always_comb begin
      active_poles_in = active_poles_ff;
      gain_in         = gain_ff;
      if (csr_valid) begin
         unique case (csr_type'(csr_index))
            CSR_ACTIVE_POLES: active_poles_in = csr_wdata[POLES_W-1:0];
            CSR_OUTPUT_GAIN:  gain_in         = csr_wdata;
            default:          gain_in         = gain_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_poles_ff <= POLES_RESET;
         gain_ff         <= GAIN_RESET;
      end else begin
         active_poles_ff <= active_poles_in;
         gain_ff         <= gain_in;
      end
   end

   dfiir_ctrl #(
      .MAX_POLES (MAX_POLES)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .pole_count    (pole_count),
      .rsp_free      (rsp_free),
      .ctl           (ctl),
      .rd_addr       (rd_addr),
      .wr_addr       (wr_addr)
   );

   // Weight stores are written straight from the request word.
   dfiir_ram #(
      .WIDTH (WEIGHT_W),
      .DEPTH (MAX_POLES)
   ) u_ff_ram (
      .clock   (clock),
      .wr_en   (req_fire && req_operation == OP_FF_WRITE && weight_ok),
      .wr_addr (AW'(req_weight_index)),
      .wr_data (req_weight_value),
      .rd_en   (ctl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ff_rd)
   );

   dfiir_ram #(
      .WIDTH (WEIGHT_W),
      .DEPTH (MAX_POLES)
   ) u_fb_ram (
      .clock   (clock),
      .wr_en   (req_fire && req_operation == OP_FB_WRITE && weight_ok),
      .wr_addr (AW'(req_weight_index)),
      .wr_data (req_weight_value),
      .rd_en   (ctl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (fb_rd)
   );

   // One history row holds the input sample and the stored sum of a tap.
   // During the sweep each row read but the oldest is written back one place older;
   // after the sweep the newest place takes the new sample and the new sum.
   assign hist_wdata = ctl.final_we ? {x_ff, sum_sat} : {hist_in_m, hist_out_m};

   dfiir_ram #(
      .WIDTH (HROW_W),
      .DEPTH (MAX_POLES)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (ctl.shift_we || ctl.final_we),
      .wr_addr (wr_addr),
      .wr_data (hist_wdata),
      .rd_en   (ctl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (hist_rd)
   );

   // A history row that was never written since reset or a clear reads as zero.
   assign hist_in_m  = rd_vld_ff ? hist_rd[HROW_W-1:HIST_W] : '0;
   assign hist_out_m = rd_vld_ff ? hist_rd[HIST_W-1:0] : '0;

   always_comb begin
      hist_vld_in = hist_vld_ff;
      if (ctl.hist_clear) begin
         hist_vld_in = '0;
      end else if (ctl.shift_we || ctl.final_we) begin
         hist_vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_vld_ff <= '0;
         rd_vld_ff   <= 1'b0;
      end else begin
         hist_vld_ff <= hist_vld_in;
         if (ctl.rd_en) begin
            rd_vld_ff <= hist_vld_ff[rd_addr];
         end
      end
      if (req_fire && req_operation == OP_SAMPLE) begin
         x_ff <= req_sample_in;
      end
   end

   dfiir_mac #(
      .MAX_POLES            (MAX_POLES),
      .WEIGHT_FRACTION_BITS (WEIGHT_FRACTION_BITS)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .sample     (req_sample_in),
      .ff_weight  (ff_rd),
      .fb_weight  (fb_rd),
      .hist_in    (hist_in_m),
      .hist_out   (hist_out_m),
      .gain       (gain_ff),
      .sum_sat    (sum_sat),
      .out_sample (out_sample),
      .out_clip   (out_clip)
   );

   // Result word register; it frees up in the cycle the receiver takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (ctl.out_load) begin
         rsp_sample_ff  <= out_sample;
         rsp_clipped_ff <= out_clip;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_clipped    = rsp_clipped_ff;

endmodule

// ----- design/dfiir_checker.sv -----
// Port-level checker for the IIR filter top level and its bind statement.
module dfiir_checker import dfiir_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic [OP_W-1:0]            req_operation,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [SAMPLE_W-1:0] rsp_sample_out,
   input logic                       rsp_clipped
);

   // A stalled result word stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out)
                                  && $stable(rsp_clipped))
      else $error("result word changed while stalled");

   // A clipped result sits on one of the two rails.
   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |-> (rsp_sample_out == SAMPLE_MAX)
                                   || (rsp_sample_out == SAMPLE_MIN))
      else $error("clipped result is not saturated");

   // A sample word keeps the block busy for at least the next cycle.
   a_busy_after_sample: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == OP_SAMPLE |=> !req_ready)
      else $error("request taken right after a sample word");

   // Weight writes and clears never produce a result word.
   a_no_result_from_write: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation != OP_SAMPLE && !rsp_valid
      |=> !rsp_valid)
      else $error("result word appeared after a non-sample word");

endmodule

bind direct_form_iir_filter_top dfiir_checker u_checker (.*);

// ----- tb/sv/direct_form_iir_filter_top_tb.sv -----
// Self-checking testbench of the direct-form-I recursive filter top level.
module direct_form_iir_filter_top_tb;
   import dfiir_pkg::*;

   // The predictor uses the same sizes as the default build of the block.
   localparam int TAPS   = DEF_MAX_POLES;
   localparam int TAP_AW = $clog2(TAPS);
   localparam int FRAC   = DEF_WEIGHT_FRACTION_BITS;
   localparam int WIDE_W = 128;

   // Saturation bounds of the stored sums, widened to the accumulator.
   localparam logic signed [WIDE_W-1:0] HIST_TOP = (WIDE_W'(1) <<< (HIST_W - 1)) - 1;
   localparam logic signed [WIDE_W-1:0] HIST_BOT = -HIST_TOP - 1;

   localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_W - 1){1'b1}}};
   localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_W - 1){1'b0}}};
   localparam logic signed [GAIN_W-1:0]   GAIN_MAX   = {1'b0, {(GAIN_W - 1){1'b1}}};
   localparam logic signed [GAIN_W-1:0]   GAIN_MIN   = {1'b1, {(GAIN_W - 1){1'b0}}};

   // Weight writes and history clears leave the block idle, so a short pause after the
   // last result word is enough before touching the registers. The closing pause
   // covers one full sample at the largest tap count.
   localparam int SETTLE_CYCLES   = 10;
   localparam int DRAIN_CYCLES    = 6 * TAPS + 20;
   localparam int PHASES          = 12;
   localparam int WORDS_PER_PHASE = 140;
   localparam int RUN_LIMIT       = 40_000_000;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       clip;
   } result_word_type;

   logic                        clock            = 1'b0;
   logic                        reset            = 1'b1;
   logic                        req_valid        = 1'b0;
   logic                        req_ready;
   logic [OP_W-1:0]             req_operation    = OP_SAMPLE;
   logic signed [SAMPLE_W-1:0]  req_sample_in    = '0;
   logic [POLES_W-1:0]          req_weight_index = '0;
   logic signed [WEIGHT_W-1:0]  req_weight_value = '0;
   logic                        rsp_valid;
   logic                        rsp_ready        = 1'b0;
   logic signed [SAMPLE_W-1:0]  rsp_sample_out;
   logic                        rsp_clipped;
   logic                        csr_valid        = 1'b0;
   logic                        csr_ready;
   logic                        csr_index        = CSR_ACTIVE_POLES;
   logic [CSR_DATA_W-1:0]       csr_wdata        = '0;

   // Predictor state: weights, both histories and the two registers.
   logic signed [WEIGHT_W-1:0]  ff_weight [TAPS];
   logic signed [WEIGHT_W-1:0]  fb_weight [TAPS];
   logic signed [SAMPLE_W-1:0]  in_hist   [TAPS];
   logic signed [HIST_W-1:0]    out_hist  [TAPS];
   logic [POLES_W-1:0]          poles_cfg;
   logic signed [GAIN_W-1:0]    gain_cfg;

   result_word_type expected_results[$];
   int              error_count;
   int              burst_left;
   int              ready_left;
   int              stall_left;

   direct_form_iir_filter_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_sample_in    (req_sample_in),
      .req_weight_index (req_weight_index),
      .req_weight_value (req_weight_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_out   (rsp_sample_out),
      .rsp_clipped      (rsp_clipped),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Applies one accepted request word to the predictor. A sample word sums the new
   // sample, the feedforward taps (shifted up to the feedback scale) and the feedback
   // taps at full precision, floors the sum back to the history scale, clamps it to
   // 64 bits and stores it. The stored sum times the gain, rounded half up and
   // clamped to 24 bits, is the expected result word.
   task automatic compute_filter(input op_type op,
                                 input logic signed [SAMPLE_W-1:0] smp,
                                 input logic [POLES_W-1:0] idx,
                                 input logic signed [WEIGHT_W-1:0] wv);
      logic signed [WIDE_W-1:0] acc;
      logic signed [WIDE_W-1:0] lhs;
      logic signed [WIDE_W-1:0] rhs;
      logic signed [HIST_W-1:0] sum;
      result_word_type          res;
      int                       taps;
      int                       j;
      case (op)
         OP_FF_WRITE: begin
            // Indexes past the last tap are dropped.
            if (idx < TAPS) ff_weight[idx] = wv;
         end
         OP_FB_WRITE: begin
            if (idx < TAPS) fb_weight[idx] = wv;
         end
         OP_CLEAR: begin
            for (j = 0; j < TAPS; j++) begin
               in_hist[TAP_AW'(j)]  = '0;
               out_hist[TAP_AW'(j)] = '0;
            end
         end
         OP_SAMPLE: begin
            // Tap counts above the store depth act as the full depth.
            taps = (poles_cfg > TAPS) ? TAPS : poles_cfg;
            acc = WIDE_W'(smp);
            acc = acc <<< (2 * FRAC);
            for (j = 0; j < taps; j++) begin
               lhs = WIDE_W'(ff_weight[TAP_AW'(j)]);
               rhs = WIDE_W'(in_hist[TAP_AW'(j)]);
               acc = acc + ((lhs * rhs) <<< FRAC);
               lhs = WIDE_W'(fb_weight[TAP_AW'(j)]);
               rhs = WIDE_W'(out_hist[TAP_AW'(j)]);
               acc = acc + lhs * rhs;
            end
            acc = acc >>> FRAC;
            // Clamping the stored sum is silent: it never sets the clip flag.
            if (acc > HIST_TOP) sum = HIST_TOP[HIST_W-1:0];
            else if (acc < HIST_BOT) sum = HIST_BOT[HIST_W-1:0];
            else sum = acc[HIST_W-1:0];
            // Oldest tap sits at entry 0, newest at entry taps-1. With no taps
            // nothing is kept.
            for (j = 0; j + 1 < taps; j++) begin
               in_hist[TAP_AW'(j)]  = in_hist[TAP_AW'(j + 1)];
               out_hist[TAP_AW'(j)] = out_hist[TAP_AW'(j + 1)];
            end
            if (taps > 0) begin
               in_hist[TAP_AW'(taps - 1)]  = smp;
               out_hist[TAP_AW'(taps - 1)] = sum;
            end
            lhs = WIDE_W'(sum);
            rhs = WIDE_W'(gain_cfg);
            acc = lhs * rhs + (WIDE_W'(1) <<< (FRAC + GAIN_FRAC_W - 1));
            acc = acc >>> (FRAC + GAIN_FRAC_W);
            res.clip = 1'b0;
            if (acc > SAMPLE_MAX) begin
               res.sample = SAMPLE_MAX;
               res.clip   = 1'b1;
            end else if (acc < SAMPLE_MIN) begin
               res.sample = SAMPLE_MIN;
               res.clip   = 1'b1;
            end else begin
               res.sample = acc[SAMPLE_W-1:0];
            end
            expected_results.push_back(res);
         end
      endcase
   endtask

   // Sends one request word. Words go out in bursts; a fresh burst starts after a
   // random gap with valid low, while inside a burst valid stays high from one word
   // to the next.
   task automatic send_word(input op_type op,
                            input logic signed [SAMPLE_W-1:0] smp,
                            input logic [POLES_W-1:0] idx,
                            input logic signed [WEIGHT_W-1:0] wv);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 140)
                                           : $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_sample_in    <= smp;
      req_weight_index <= idx;
      req_weight_value <= wv;
      do @(posedge clock); while (req_ready !== 1'b1);
      compute_filter(op, smp, idx, wv);
   endtask

   // Stops sending and waits until every expected result word has come back and
   // any trailing weight write or clear has finished.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes both registers back to back once the block is idle. Bits above the tap
   // count field carry random junk, which the block must ignore.
   task automatic write_config(input logic [POLES_W-1:0] poles,
                               input logic signed [GAIN_W-1:0] gain);
      logic [CSR_DATA_W-1:0] data;
      wait_idle();
      data = CSR_DATA_W'({$urandom, $urandom});
      data[POLES_W-1:0] = poles;
      csr_valid <= 1'b1;
      csr_index <= CSR_ACTIVE_POLES;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      poles_cfg = poles;
      csr_index <= CSR_OUTPUT_GAIN;
      csr_wdata <= gain;
      do @(posedge clock); while (csr_ready !== 1'b1);
      gain_cfg = gain;
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 19))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return '0;
         3:       return '1;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // Mostly small weights so the recursion stays in range for a while; now and then
   // a full-range weight that drives the stored sums into saturation.
   function automatic logic signed [WEIGHT_W-1:0] pick_weight(input bit feedback);
      logic signed [WEIGHT_W-1:0] full;
      logic signed [22:0]         ff_part;
      logic signed [20:0]         fb_part;
      full    = WEIGHT_W'({$urandom, $urandom});
      ff_part = full[22:0];
      fb_part = full[20:0];
      if ($urandom_range(0, 15) == 0) return full;
      if (feedback) return WEIGHT_W'(fb_part);
      return WEIGHT_W'(ff_part);
   endfunction

   // Gains mostly within plus or minus 2.0, with extremes and full-range values.
   function automatic logic signed [GAIN_W-1:0] pick_gain();
      logic signed [GAIN_W-1:0] full;
      logic signed [33:0]       near;
      full = GAIN_W'({$urandom, $urandom});
      near = full[33:0];
      case ($urandom_range(0, 15))
         0:       return GAIN_MAX;
         1:       return GAIN_MIN;
         2, 3:    return full;
         default: return GAIN_W'(near);
      endcase
   endfunction

   function automatic logic [POLES_W-1:0] pick_index();
      if ($urandom_range(0, 7) == 0)
         return POLES_W'($urandom_range(TAPS, 2 ** POLES_W - 1));
      return POLES_W'($urandom_range(0, TAPS - 1));
   endfunction

   task automatic send_random_word();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 72)
         send_word(OP_SAMPLE, pick_sample(), POLES_W'($urandom),
                   WEIGHT_W'({$urandom, $urandom}));
      else if (roll < 84)
         send_word(OP_FF_WRITE, SAMPLE_W'($urandom), pick_index(), pick_weight(1'b0));
      else if (roll < 96)
         send_word(OP_FB_WRITE, SAMPLE_W'($urandom), pick_index(), pick_weight(1'b1));
      else
         send_word(OP_CLEAR, SAMPLE_W'($urandom), POLES_W'($urandom),
                   WEIGHT_W'({$urandom, $urandom}));
   endtask

   // Filtering at the reset settings: two taps and unity gain. Only the two taps in
   // use get weights before the first sample.
   task automatic test_reset_config();
      send_word(OP_FF_WRITE, '0, 5'd0, 48'sd8388608);
      send_word(OP_FF_WRITE, '0, 5'd1, -48'sd4194304);
      send_word(OP_FB_WRITE, '0, 5'd0, 48'sd2097152);
      send_word(OP_FB_WRITE, '0, 5'd1, -48'sd8388608);
      send_word(OP_SAMPLE, SAMPLE_MAX, '0, '0);
      send_word(OP_SAMPLE, SAMPLE_MIN, '0, '0);
      send_word(OP_SAMPLE, '0, '0, '0);
      send_word(OP_SAMPLE, '1, '0, '0);
      send_word(OP_SAMPLE, 24'sd1, '0, '0);
   endtask

   // Weight writes past the last tap must leave the weights alone; a clear then
   // restarts from empty histories.
   task automatic test_ignored_index();
      send_word(OP_FF_WRITE, '0, 5'(TAPS), WEIGHT_MAX);
      send_word(OP_FB_WRITE, '0, 5'd31, WEIGHT_MIN);
      send_word(OP_FF_WRITE, '0, 5'd31, WEIGHT_MIN);
      send_word(OP_SAMPLE, 24'sd1000, '0, '0);
      send_word(OP_CLEAR, '0, '0, '0);
      send_word(OP_SAMPLE, SAMPLE_MAX, '0, '0);
   endtask

   // With no taps the output is just the sample times the gain, which also lets the
   // gain extremes push the output into clipping in both directions.
   task automatic test_no_taps();
      write_config(5'd0, GAIN_RESET);
      send_word(OP_SAMPLE, 24'sd12345, '0, '0);
      send_word(OP_SAMPLE, SAMPLE_MIN, '0, '0);
      write_config(5'd0, GAIN_MAX);
      send_word(OP_SAMPLE, SAMPLE_MAX, '0, '0);
      send_word(OP_SAMPLE, '1, '0, '0);
      write_config(5'd0, GAIN_MIN);
      send_word(OP_SAMPLE, SAMPLE_MAX, '0, '0);
      send_word(OP_SAMPLE, SAMPLE_MIN, '0, '0);
   endtask

   // Extreme weights blow the stored sums up to their 64-bit limits.
   task automatic test_weight_extremes();
      write_config(5'd2, GAIN_RESET);
      send_word(OP_FF_WRITE, '0, 5'd0, WEIGHT_MAX);
      send_word(OP_FB_WRITE, '0, 5'd1, WEIGHT_MIN);
      send_word(OP_SAMPLE, SAMPLE_MAX, '0, '0);
      send_word(OP_SAMPLE, SAMPLE_MAX, '0, '0);
      send_word(OP_SAMPLE, SAMPLE_MAX, '0, '0);
      send_word(OP_SAMPLE, SAMPLE_MIN, '0, '0);
      send_word(OP_CLEAR, '0, '0, '0);
   endtask

   // Loads every tap, then runs phases of random traffic, each at its own tap count
   // and gain. The first phases hit one tap, the full depth, a count past the depth
   // and no taps at all.
   task automatic test_random_traffic();
      logic [POLES_W-1:0] poles;
      int                 phase;
      int                 k;
      for (k = 0; k < TAPS; k++) begin
         send_word(OP_FF_WRITE, '0, 5'(k), pick_weight(1'b0));
         send_word(OP_FB_WRITE, '0, 5'(k), pick_weight(1'b1));
      end
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       poles = 5'd1;
            1:       poles = 5'(TAPS);
            2:       poles = 5'd31;
            3:       poles = 5'd0;
            default: poles = POLES_W'($urandom_range(0, 2 ** POLES_W - 1));
         endcase
         write_config(poles, pick_gain());
         repeat (WORDS_PER_PHASE) send_random_word();
      end
   endtask

   // The receiver alternates runs of ready with stalls, with an occasional long run
   // where it never stalls.
   always @(posedge clock) begin
      if (ready_left != 0) begin
         ready_left--;
         rsp_ready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         ready_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
         stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         rsp_ready <= 1'b1;
      end
   end

   // Every result word taken by the receiver is checked against the oldest
   // expectation, field by field.
   always @(posedge clock) begin : check_results
      result_word_type want;
      if (reset !== 1'b1 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (expected_results.size() == 0) begin
            error_count++;
            $display("%0t: result word with nothing expected, sample_out %0d clipped %0b",
                     $time, rsp_sample_out, rsp_clipped);
         end else begin
            want = expected_results.pop_front();
            if (rsp_sample_out !== want.sample) begin
               error_count++;
               $display("%0t: sample_out expected %0d, actual %0d",
                        $time, want.sample, rsp_sample_out);
            end
            if (rsp_clipped !== want.clip) begin
               error_count++;
               $display("%0t: clipped expected %0b, actual %0b",
                        $time, want.clip, rsp_clipped);
            end
         end
      end
   end

   initial begin
      poles_cfg = POLES_RESET;
      gain_cfg  = GAIN_RESET;
      for (int j = 0; j < TAPS; j++) begin
         ff_weight[TAP_AW'(j)] = '0;
         fb_weight[TAP_AW'(j)] = '0;
         in_hist[TAP_AW'(j)]   = '0;
         out_hist[TAP_AW'(j)]  = '0;
      end
      error_count = 0;
      burst_left  = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_config();
      test_ignored_index();
      test_no_taps();
      test_weight_extremes();
      test_random_traffic();
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #(RUN_LIMIT);
      $display("tb: failure");
      $finish;
   end

endmodule
